### sv/mvps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvps_pkg
// Shared types and constants of the motor velocity pid step block.
// ----------------------------------------------------------------------------
package mvps_pkg;

  // saturated internal word, +/-(2^47-1)
  typedef logic signed [47:0] wide_t;
  localparam wide_t WIDE_MAX = 48'sh7FFF_FFFF_FFFF;

  // divider geometry: dividend/quotient width and constant divisor width
  localparam int unsigned QUO_W  = 61;
  localparam int unsigned DIVR_W = 13;

  // speed blending constants
  localparam logic [DIVR_W-1:0] LOW_SPEED = 13'd3200;
  localparam logic [DIVR_W-1:0] BLEND_DIV = 13'd6400;
  localparam logic [13:0]       G_BASE    = 14'd12800;

  // dead zone
  localparam logic [9:0]         DEAD_OFS = 10'd600;
  localparam logic signed [31:0] DEAD_THR = 32'sd8;

  // register indexes
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd1;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd2;
  localparam logic [2:0] REG_OUT_LIMIT   = 3'd3;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd4;

endpackage

### sv/motor_velocity_pid_step.sv
`timescale 1ns / 1ps
// Each word runs through the shared shift-add multiplier (one bit a cycle) and, for
// |vel_ref| < 3200, also through the 61-step restoring divider.
// One word at a time: the next word is taken in the cycle after the result is loaded;
// a finished word waits in the output register while the receiver stalls.
// Reset clears gains, limits, integrator and drive accumulator to zero.
// ----------------------------------------------------------------------------
// motor_velocity_pid_step
// Fixed-point velocity pid with anti-windup, low-speed blend and dead zone.
// ----------------------------------------------------------------------------
module motor_velocity_pid_step #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_error_i,
  input  logic signed [31:0] vel_ref_i,
  input  logic signed [31:0] vel_meas_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] drive_o,
  output logic signed [31:0] error_status_o
);

  localparam int unsigned AW  = (FRAC_BITS + 32 > 48) ? FRAC_BITS + 32 : 48;
  localparam int unsigned BW  = (FRAC_BITS + 3 > 24) ? FRAC_BITS + 3 : 24;
  localparam int unsigned PW  = AW + BW;
  localparam int unsigned DAW = FRAC_BITS + 16;
  localparam int unsigned QW  = mvps_pkg::QUO_W;
  localparam int unsigned XW  = QW + 1;
  localparam int unsigned DW  = 51;
  localparam logic signed [49:0] WMAX50 = 50'(mvps_pkg::WIDE_MAX);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIVG, ST_MKD, ST_ME, ST_MKP, ST_MB1, ST_MB2, ST_DIVB,
    ST_MKI, ST_DZ, ST_OUT
  } state_e;

  state_e state_q;
  logic   launched_q;
  logic   out_valid_q;

  // configuration
  logic signed [23:0] kp_q, kd_q, ki_q;
  logic [14:0]        olim_q;
  logic [30:0]        ilim_cfg_q;

  // per-word payload
  logic signed [31:0]    en_q, vref_q, vmeas_q;
  logic [BW-1:0]         g_q;
  mvps_pkg::wide_t       kd_dv_q, inner_q, xn_q, integ_q;
  logic signed [XW-1:0]  blend_q;
  logic signed [DW-1:0]  drv_q;
  logic signed [DAW-1:0] dacc_q;
  logic signed [15:0]    drive_q;
  logic signed [31:0]    err_q;

  // units
  logic          mul_start, mul_done, mul_neg;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] mul_p, mul_sh;
  logic          div_start, div_done;
  logic [QW-1:0] div_n, div_q;
  logic [mvps_pkg::DIVR_W-1:0] div_d;

  // derived values
  logic signed [32:0] dv;
  logic [32:0]        dv_abs, en_abs, vref_abs;
  logic [11:0]        a;
  logic               low_spd;
  logic [13:0]        g_num;
  logic [23:0]        kp_abs, kd_abs, ki_abs;
  logic               gain_ovf, plain_ovf;
  mvps_pkg::wide_t    gain_val, plain_val, ilim, integ_new, it0, isum;
  logic signed [XW-1:0] prod_sgn;
  logic [XW-2:0]      blend_abs;
  logic signed [DW-1:0] dz, drv2, lim, drv_fin;
  logic [DAW-1:0]     dacc_abs, dmag;
  logic [15:0]        dnarrow;
  logic [AW-1:0]      ilim_sh;
  logic               op_state, is_mul, step_done;

  function automatic mvps_pkg::wide_t to_wide(input logic ovf, input logic [46:0] m,
                                              input logic neg);
    logic [46:0]     mm;
    mvps_pkg::wide_t v;
    mm = ovf ? {47{1'b1}} : m;
    v  = $signed({1'b0, mm});
    return neg ? -v : v;
  endfunction

  function automatic mvps_pkg::wide_t sat_add(input mvps_pkg::wide_t x,
                                              input mvps_pkg::wide_t y);
    logic signed [49:0] s;
    s = 50'(x) + 50'(y);
    if (s > WMAX50) return mvps_pkg::WIDE_MAX;
    else if (s < -WMAX50) return -mvps_pkg::WIDE_MAX;
    else return s[47:0];
  endfunction

  function automatic logic [23:0] abs24(input logic signed [23:0] v);
    return v[23] ? 24'(-v) : 24'(v);
  endfunction

  function automatic logic [47:0] abs48(input mvps_pkg::wide_t v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  // configuration port, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= '0;
      kd_q       <= '0;
      ki_q       <= '0;
      olim_q     <= '0;
      ilim_cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mvps_pkg::REG_PROP_GAIN:   kp_q       <= cfg_data_i[23:0];
        mvps_pkg::REG_DERIV_GAIN:  kd_q       <= cfg_data_i[23:0];
        mvps_pkg::REG_INTEG_GAIN:  ki_q       <= cfg_data_i[23:0];
        mvps_pkg::REG_OUT_LIMIT:   olim_q     <= cfg_data_i[14:0];
        mvps_pkg::REG_INTEG_LIMIT: ilim_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operand magnitudes and speed class
  always_comb begin
    dv       = {vref_q[31], vref_q} - {vmeas_q[31], vmeas_q};
    dv_abs   = dv[32] ? 33'(-dv) : 33'(dv);
    en_abs   = en_q[31] ? 33'(-{en_q[31], en_q}) : 33'({en_q[31], en_q});
    vref_abs = vref_q[31] ? 33'(-{vref_q[31], vref_q}) : 33'({vref_q[31], vref_q});
    a        = vref_abs[11:0];
    low_spd  = vref_abs < 33'(mvps_pkg::LOW_SPEED);
    g_num    = mvps_pkg::G_BASE - (14'({a, 1'b0}) + 14'(a));
    kp_abs   = abs24(kp_q);
    kd_abs   = abs24(kd_q);
    ki_abs   = abs24(ki_q);
  end

  // sequencing of the shared units
  always_comb begin
    op_state = 1'b0;
    is_mul   = 1'b1;
    mul_a    = '0;
    mul_b    = '0;
    mul_neg  = 1'b0;
    div_n    = '0;
    div_d    = mvps_pkg::LOW_SPEED;
    unique case (state_q)
      ST_DIVG: begin
        op_state = low_spd;
        is_mul   = 1'b0;
        div_n    = QW'(g_num) << FRAC_BITS;
      end
      ST_MKD: begin
        op_state = 1'b1;
        mul_a    = AW'(dv_abs[31:0]) << FRAC_BITS;
        mul_b    = BW'(kd_abs);
        mul_neg  = kd_q[23] ^ dv[32];
      end
      ST_ME: begin
        op_state = 1'b1;
        mul_a    = AW'(en_abs[31:0]);
        mul_b    = low_spd ? g_q : (BW'(1) << FRAC_BITS);
        mul_neg  = en_q[31];
      end
      ST_MKP: begin
        op_state = 1'b1;
        mul_a    = AW'(abs48(inner_q));
        mul_b    = BW'(kp_abs);
        mul_neg  = kp_q[23] ^ inner_q[47];
      end
      ST_MB1: begin
        op_state = 1'b1;
        mul_a    = AW'(dacc_abs);
        mul_b    = BW'(mvps_pkg::LOW_SPEED - 13'(a));
        mul_neg  = dacc_q[DAW-1];
      end
      ST_MB2: begin
        op_state = 1'b1;
        mul_a    = AW'(abs48(xn_q));
        mul_b    = BW'(mvps_pkg::LOW_SPEED + 13'(a));
        mul_neg  = xn_q[47];
      end
      ST_DIVB: begin
        op_state = 1'b1;
        is_mul   = 1'b0;
        div_n    = blend_abs;
        div_d    = mvps_pkg::BLEND_DIV;
      end
      ST_MKI: begin
        op_state = 1'b1;
        mul_a    = AW'(abs48(integ_q));
        mul_b    = BW'(ki_abs);
        mul_neg  = ki_q[23] ^ integ_q[47];
      end
      default: ;
    endcase
    mul_start = op_state && !launched_q && is_mul;
    div_start = op_state && !launched_q && !is_mul;
    step_done = launched_q && (mul_done || div_done);
  end

  mvps_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  mvps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // product post-processing, integrator update, dead zone and clamp
  always_comb begin
    mul_sh    = mul_p >> FRAC_BITS;
    gain_ovf  = (|mul_p[PW-1:64]) || (|mul_sh[PW-1:47]);
    plain_ovf = |mul_p[PW-1:47];
    gain_val  = to_wide(gain_ovf, mul_sh[46:0], mul_neg);
    plain_val = to_wide(plain_ovf, mul_p[46:0], mul_neg);
    prod_sgn  = mul_neg ? -$signed({1'b0, mul_p[XW-2:0]}) : $signed({1'b0, mul_p[XW-2:0]});
    blend_abs = blend_q[XW-1] ? (XW-1)'(-blend_q) : blend_q[XW-2:0];

    ilim_sh = AW'(ilim_cfg_q) << FRAC_BITS;
    ilim    = (|ilim_sh[AW-1:47]) ? mvps_pkg::WIDE_MAX : $signed({1'b0, ilim_sh[46:0]});
    it0     = (integ_q[47] != gain_val[47]) ? '0 : integ_q;
    isum    = sat_add(it0, gain_val);
    if (isum > ilim) integ_new = ilim;
    else if (isum < -ilim) integ_new = -ilim;
    else integ_new = isum;

    dz = $signed(DW'(mvps_pkg::DEAD_OFS) << FRAC_BITS);
    if (vref_q > mvps_pkg::DEAD_THR) drv2 = drv_q + dz;
    else if (vref_q < -mvps_pkg::DEAD_THR) drv2 = drv_q - dz;
    else drv2 = drv_q;
    lim = $signed(DW'(olim_q) << FRAC_BITS);
    if (drv2 > lim) drv_fin = lim;
    else if (drv2 < -lim) drv_fin = -lim;
    else drv_fin = drv2;

    dacc_abs = dacc_q[DAW-1] ? DAW'(-dacc_q) : DAW'(dacc_q);
    dmag     = dacc_abs >> FRAC_BITS;
    dnarrow  = dmag[15:0];
  end

  // sequencer, integrator, drive accumulator and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      dacc_q      <= '0;
      drive_q     <= '0;
      err_q       <= '0;
    end else begin
      if (op_state && !launched_q) launched_q <= 1'b1;
      else if (step_done) launched_q <= 1'b0;
      // a new word may replace one taken at the same edge
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
        drive_q     <= dacc_q[DAW-1] ? -$signed(dnarrow) : $signed(dnarrow);
        err_q       <= en_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_DIVG;
        ST_DIVG: if (!low_spd || step_done) state_q <= ST_MKD;
        ST_MKD:  if (step_done) state_q <= ST_ME;
        ST_ME:   if (step_done) state_q <= ST_MKP;
        ST_MKP: begin
          if (step_done) begin
            if (low_spd) begin
              integ_q <= '0;
              state_q <= ST_MB1;
            end else begin
              integ_q <= integ_new;
              state_q <= ST_MKI;
            end
          end
        end
        ST_MB1:  if (step_done) state_q <= ST_MB2;
        ST_MB2:  if (step_done) state_q <= ST_DIVB;
        ST_DIVB: if (step_done) state_q <= ST_DZ;
        ST_MKI:  if (step_done) state_q <= ST_DZ;
        ST_DZ: begin
          dacc_q  <= drv_fin[DAW-1:0];
          state_q <= ST_OUT;
        end
        ST_OUT:  if (!out_valid_q || out_ready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      en_q    <= pos_error_i;
      vref_q  <= vel_ref_i;
      vmeas_q <= vel_meas_i;
    end
    if (step_done) begin
      unique case (state_q)
        ST_DIVG: g_q     <= div_q[BW-1:0];
        ST_MKD:  kd_dv_q <= gain_val;
        ST_ME:   inner_q <= sat_add(plain_val, kd_dv_q);
        ST_MKP:  xn_q    <= gain_val;
        ST_MB1:  blend_q <= prod_sgn;
        ST_MB2:  blend_q <= blend_q + prod_sgn;
        ST_DIVB: drv_q   <= blend_q[XW-1] ? -$signed({1'b0, div_q[DW-2:0]})
                                          : $signed({1'b0, div_q[DW-2:0]});
        ST_MKI:  drv_q   <= DW'(sat_add(xn_q, gain_val));
        default: ;
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign drive_o        = drive_q;
  assign error_status_o = err_q;

endmodule

### sv/mvps_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvps_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mvps_mul #(
  parameter int unsigned AW = 48,
  parameter int unsigned BW = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] p_o
);

  localparam int unsigned PW = AW + BW;
  localparam int unsigned CW = $clog2(BW);

  logic [PW-1:0] prod_q;
  logic [AW-1:0] a_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [AW:0]   sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, prod_q[PW-1:BW]} + {1'b0, (prod_q[0] ? a_q : {AW{1'b0}})};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // product shift register, multiplier bits leave at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= {{AW{1'b0}}, b_i};
      a_q    <= a_i;
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = prod_q;

endmodule

### sv/mvps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvps_div
// Restoring divider by a narrow divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mvps_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mvps_pkg::QUO_W-1:0]  n_i,
  input  logic [mvps_pkg::DIVR_W-1:0] d_i,
  output logic                        done_o,
  output logic [mvps_pkg::QUO_W-1:0]  q_o
);

  localparam int unsigned QW = mvps_pkg::QUO_W;
  localparam int unsigned RW = mvps_pkg::DIVR_W;
  localparam int unsigned CW = $clog2(QW);

  logic [RW-1:0] rem_q;
  logic [RW-1:0] d_q;
  logic [QW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [RW:0]   shifted;
  logic [RW:0]   diff;
  logic          ge;

  // trial subtract of the next dividend bit
  assign shifted = {rem_q, quo_q[QW-1]};
  assign diff    = shifted - {1'b0, d_q};
  assign ge      = shifted >= {1'b0, d_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      d_q   <= d_i;
      quo_q <= n_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[RW-1:0] : shifted[RW-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign q_o    = quo_q;

endmodule

### dv/motor_velocity_pid_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_velocity_pid_step_tb
// Self-checking bench for the velocity pid step. Gain and limit phases run
// with changing idle and stall patterns. A scoreboard predicts drive and
// status for every accepted word and checks results in order.
// ----------------------------------------------------------------------------
module motor_velocity_pid_step_tb;

  localparam longint ONE      = 64'sd65536;
  localparam longint SAT_MAX  = 64'sh7FFF_FFFF_FFFF;
  localparam int     QUIET_LIM = 20000;
  localparam int     TAIL_CYC  = 400;

  typedef struct {
    logic signed [15:0] drive;
    logic signed [31:0] err;
  } pid_result_t;

  // ---------------------------------------------------------------------------
  // scoreboard: pid predictor and queue of pending results
  // ---------------------------------------------------------------------------
  class pid_scoreboard;
    longint kp, kd, ki, out_lim, integ_lim;
    longint acc, integ;
    pid_result_t pending_q[$];
    int fails;

    function new();
      kp = 0; kd = 0; ki = 0; out_lim = 0; integ_lim = 0;
      acc = 0; integ = 0; fails = 0;
    endfunction

    function longint clip(longint x);
      if (x > SAT_MAX) return SAT_MAX;
      if (x < -SAT_MAX) return -SAT_MAX;
      return x;
    endfunction

    // gain times value, magnitude truncated, saturated
    function longint gmul(longint gain, longint val);
      logic [127:0] prod;
      longint unsigned ua, ub;
      ua = (gain < 0) ? -gain : gain;
      ub = (val < 0) ? -val : val;
      if (ua == 0 || ub == 0) return 0;
      prod = 128'(ua) * 128'(ub);
      if (prod > 128'hFFFF_FFFF_FFFF_FFFF) prod = 128'(SAT_MAX);
      else prod = prod >> 16;
      if (prod > 128'(SAT_MAX)) prod = 128'(SAT_MAX);
      return ((gain < 0) != (val < 0)) ? -longint'(prod) : longint'(prod);
    endfunction

    function void note_config(logic [2:0] idx, logic [30:0] d);
      unique case (idx)
        mvps_pkg::REG_PROP_GAIN:   kp = longint'($signed(d[23:0]));
        mvps_pkg::REG_DERIV_GAIN:  kd = longint'($signed(d[23:0]));
        mvps_pkg::REG_INTEG_GAIN:  ki = longint'($signed(d[23:0]));
        mvps_pkg::REG_OUT_LIMIT:   out_lim = longint'(d[14:0]);
        mvps_pkg::REG_INTEG_LIMIT: integ_lim = longint'(d[30:0]);
        default: ;
      endcase
    endfunction

    function void note_input(longint pe, longint vr, longint vm);
      longint dvq, drv, a, g, inner, pd, xn, ilim, lim;
      longint unsigned dm;
      pid_result_t r;
      dvq = (vr - vm) * ONE;
      if (vr > -3200 && vr < 3200) begin
        // low speed: blend toward weighted pd term
        a = (vr < 0) ? -vr : vr;
        g = ((12800 - 3 * a) * ONE) / 3200;
        inner = clip(clip(pe * g) + gmul(kd, dvq));
        pd = gmul(kp, inner);
        integ = 0;
        drv = ((3200 - a) * acc + (3200 + a) * pd) / 6400;
      end else begin
        // integrating path with anti-windup clamp
        inner = clip(clip(pe * ONE) + gmul(kd, dvq));
        xn = gmul(kp, inner);
        if ((integ < 0) != (xn < 0)) integ = 0;
        integ = clip(integ + xn);
        ilim = clip(integ_lim * ONE);
        if (integ > ilim) integ = ilim;
        else if (integ < -ilim) integ = -ilim;
        drv = clip(xn + gmul(ki, integ));
      end
      // dead zone offset and output clamp
      if (vr > 8) drv += 600 * ONE;
      else if (vr < -8) drv -= 600 * ONE;
      lim = out_lim * ONE;
      if (drv > lim) drv = lim;
      else if (drv < -lim) drv = -lim;
      acc = drv;
      dm = ((drv < 0) ? -drv : drv) >> 16;
      r.drive = (drv < 0) ? 16'(-dm) : 16'(dm);
      r.err = 32'(pe);
      pending_q.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] drive, logic signed [31:0] err);
      pid_result_t r;
      if (pending_q.size() == 0) begin
        $error("unexpected word: drive %0d error_status %0d", drive, err);
        fails++;
        return;
      end
      r = pending_q.pop_front();
      if (drive !== r.drive) begin
        $error("drive: expected %0d actual %0d", r.drive, drive);
        fails++;
      end
      if (err !== r.err) begin
        $error("error_status: expected %0d actual %0d", r.err, err);
        fails++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [30:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] pos_error_i = '0;
  logic signed [31:0] vel_ref_i = '0;
  logic signed [31:0] vel_meas_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] drive_o;
  logic signed [31:0] error_status_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          quiet_cnt = 0;
  pid_scoreboard sb = new();

  always #2 clk_i = ~clk_i;

  motor_velocity_pid_step u_top (.*);

  // receiver stall pattern
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitors: config, input and result words
  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) sb.note_config(cfg_index_i, cfg_data_i);
    if (in_valid_i && in_ready_o)
      sb.note_input(longint'(pos_error_i), longint'(vel_ref_i), longint'(vel_meas_i));
    if (out_valid_o && out_ready_i) sb.check_result(drive_o, error_status_o);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QUIET_LIM) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // one register write, valid stays up for a following write
  task automatic write_reg(logic [2:0] idx, logic [30:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // gains carry random junk above bit 23, the output limit above bit 14
  task automatic set_gains(int kp, int kd, int ki, int olim, int ilim);
    logic [30:0] junk;
    junk = 31'($urandom);
    write_reg(mvps_pkg::REG_PROP_GAIN, {junk[30:24], kp[23:0]});
    junk = 31'($urandom);
    write_reg(mvps_pkg::REG_DERIV_GAIN, {junk[30:24], kd[23:0]});
    junk = 31'($urandom);
    write_reg(mvps_pkg::REG_INTEG_GAIN, {junk[30:24], ki[23:0]});
    junk = 31'($urandom);
    write_reg(mvps_pkg::REG_OUT_LIMIT, {junk[30:15], olim[14:0]});
    write_reg(mvps_pkg::REG_INTEG_LIMIT, ilim[30:0]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_word(int pe, int vr, int vm);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 250 : 6)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pos_error_i <= pe;
    vel_ref_i   <= vr;
    vel_meas_i  <= vm;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
  endtask

  // speed boundaries, dead zone edges, field extremes, integrator sign flip
  task automatic run_directed();
    int vr_list[14] = '{0, 3199, -3199, 3200, -3200, 8, -8, 9, -9,
                        32'sh7FFF_FFFF, 32'sh8000_0000, 100000, -100000, 1};
    foreach (vr_list[i]) send_word(1000 - i * 150, vr_list[i], vr_list[i] - 50);
    send_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_word(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_word(32'sh7FFF_FFFF, 0, 32'sh8000_0000);
    send_word(32'sh8000_0000, -5, 32'sh7FFF_FFFF);
    send_word(5000, 10000, 10000);
    send_word(5000, 10000, 10000);
    send_word(-5000, 10000, 10000);
    send_word(-5000, -10000, -10000);
    send_word(0, 3200, 3200);
    send_word(-1, -1, 0);
  endtask

  task automatic run_random(int n);
    int pe, vr, vm, sel;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 35) vr = $urandom_range(6398) - 3199;
      else if (sel < 45) vr = ($urandom_range(1) ? 1 : -1) * ($urandom_range(3) * 3191 + 8 +
                               $urandom_range(1));
      else if (sel < 88) vr = $urandom_range(200000) - 100000;
      else vr = $urandom;
      pe = ($urandom_range(4) == 0) ? $urandom : $urandom_range(40000) - 20000;
      vm = ($urandom_range(4) == 0) ? $urandom : vr + $urandom_range(2000) - 1000;
      send_word(pe, vr, vm);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 6; ph++) begin
      unique case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      unique case (ph)
        0: ;
        1: set_gains(65536, 32768, 4096, 32767, 1000);
        2: set_gains(32'sh7F_FFFF, -32'sh80_0000, 32'sh7F_FFFF, 32767, 32'h7FFF_FFFF);
        3: set_gains(-32'sh80_0000, 32'sh7F_FFFF, -32'sh80_0000, 0, 0);
        4: set_gains($urandom_range(262144) - 131072, $urandom_range(65536) - 32768,
                     $urandom_range(8192) - 4096, $urandom_range(32767),
                     $urandom_range(100000));
        default: set_gains(1024, 256, 16, 5000, 1 << 20);
      endcase
      if (ph == 1 || ph == 2 || ph == 3) run_directed();
      run_random(230);
      drain();
    end
    if (sb.fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
